/* src/csrspmv_pkg.sv */
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types and constants for the CSR sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

  localparam int unsigned IndexW  = 20;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned RowNumW = 16;
  localparam int unsigned AccW    = 64;

  // Result queue depth; must cover the pipeline stages plus a couple of slots.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;
  localparam int unsigned FifoCntW  = 4;

  localparam logic signed [AccW-1:0] SumMax32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [AccW-1:0] SumMin32 = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [AccW-1:0] AccMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AccW-1:0] AccMin   = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    FuncVecWrite = 2'd0,
    FuncNonzero  = 2'd1,
    FuncEmptyRow = 2'd2
  } func_e;

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic valid;
    logic empty_row;
    logic row_end;
    logic bad;
  } op_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  row_sum;
    logic        [RowNumW-1:0] row_number;
    logic                      saturated;
    logic                      bad_column;
  } res_t;

endpackage

/* src/csrspmv_vec_store.sv */
// ----------------------------------------------------------------------------
// csrspmv_vec_store
// Local copy of the vector x: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csrspmv_vec_store #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [AddrW-1:0]                       wr_addr_i,
  input  logic signed [csrspmv_pkg::ValueW-1:0]  wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [AddrW-1:0]                       rd_addr_i,
  output logic signed [csrspmv_pkg::ValueW-1:0]  rd_data_o
);

  logic signed [csrspmv_pkg::ValueW-1:0] mem [DEPTH];
  logic signed [csrspmv_pkg::ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/csrspmv_mac.sv */
// ----------------------------------------------------------------------------
// csrspmv_mac
// Multiply stage, saturating row accumulator, row close and output clamp.
// ----------------------------------------------------------------------------
module csrspmv_mac #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  csrspmv_pkg::op_t                       op_i,
  input  logic signed [csrspmv_pkg::ValueW-1:0]  coef_i,
  input  logic signed [csrspmv_pkg::ValueW-1:0]  x_i,
  output logic [1:0]                             inflight_o,
  output logic                                   push_o,
  output csrspmv_pkg::res_t                      res_o
);

  localparam int unsigned AccW = csrspmv_pkg::AccW;

  // Product stage
  csrspmv_pkg::op_t       op2_q;
  logic signed [AccW-1:0] prod_q;

  // Row state
  logic signed [AccW-1:0]                acc_q, acc_d;
  logic                                  bad_q, bad_d;
  logic [csrspmv_pkg::RowNumW-1:0]       row_cnt_q, row_cnt_d;

  // Close stage
  logic                                  emit_q, emit_d;
  logic signed [AccW-1:0]                sum_q, sum_d;
  logic                                  ebad_q, ebad_d;
  logic [csrspmv_pkg::RowNumW-1:0]       erow_q;

  logic signed [AccW-1:0] shifted;
  logic signed [AccW-1:0] raw_sum;
  logic signed [AccW-1:0] sat_sum;
  logic                   ovf;
  logic signed [AccW-1:0] acc_next;
  logic                   bad_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op2_q     <= '0;
      acc_q     <= '0;
      bad_q     <= 1'b0;
      row_cnt_q <= '0;
      emit_q    <= 1'b0;
    end else begin
      op2_q     <= op_i;
      acc_q     <= acc_d;
      bad_q     <= bad_d;
      row_cnt_q <= row_cnt_d;
      emit_q    <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= AccW'(coef_i) * AccW'(x_i);
    sum_q  <= sum_d;
    ebad_q <= ebad_d;
    erow_q <= row_cnt_q;
  end

  // Back to the input format; >>> rounds toward minus infinity.
  assign shifted = prod_q >>> FRACTION_BITS;
  assign raw_sum = acc_q + shifted;
  assign ovf     = (acc_q[AccW-1] == shifted[AccW-1]) && (raw_sum[AccW-1] != acc_q[AccW-1]);

  always_comb begin
    sat_sum = raw_sum;
    if (ovf) begin
      sat_sum = acc_q[AccW-1] ? csrspmv_pkg::AccMin : csrspmv_pkg::AccMax;
    end
  end

  assign acc_next = op2_q.bad ? acc_q : sat_sum;
  assign bad_next = bad_q | op2_q.bad;

  always_comb begin
    acc_d     = acc_q;
    bad_d     = bad_q;
    row_cnt_d = row_cnt_q;
    emit_d    = 1'b0;
    sum_d     = acc_next;
    ebad_d    = bad_next;
    if (op2_q.valid) begin
      if (op2_q.empty_row) begin
        // drop any partial row and close with zero
        emit_d    = 1'b1;
        sum_d     = '0;
        ebad_d    = 1'b0;
        acc_d     = '0;
        bad_d     = 1'b0;
        row_cnt_d = row_cnt_q + 1'b1;
      end else if (op2_q.row_end) begin
        emit_d    = 1'b1;
        acc_d     = '0;
        bad_d     = 1'b0;
        row_cnt_d = row_cnt_q + 1'b1;
      end else begin
        acc_d = acc_next;
        bad_d = bad_next;
      end
    end
  end

  // Clamp the closed row to 32 bits on the way into the result queue.
  always_comb begin
    res_o.row_number = erow_q;
    res_o.bad_column = ebad_q;
    res_o.saturated  = 1'b0;
    res_o.row_sum    = sum_q[csrspmv_pkg::ValueW-1:0];
    if (sum_q > csrspmv_pkg::SumMax32) begin
      res_o.saturated = 1'b1;
      res_o.row_sum   = csrspmv_pkg::SumMax32[csrspmv_pkg::ValueW-1:0];
    end else if (sum_q < csrspmv_pkg::SumMin32) begin
      res_o.saturated = 1'b1;
      res_o.row_sum   = csrspmv_pkg::SumMin32[csrspmv_pkg::ValueW-1:0];
    end
  end

  assign push_o     = emit_q;
  assign inflight_o = {1'b0, op2_q.valid} + {1'b0, emit_q};

endmodule

/* src/csrspmv_out_fifo.sv */
// ----------------------------------------------------------------------------
// csrspmv_out_fifo
// Small result queue between the pipeline and the output channel.
// ----------------------------------------------------------------------------
module csrspmv_out_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  csrspmv_pkg::res_t                    push_data_i,
  input  logic                                 pop_i,
  output logic                                 not_empty_o,
  output csrspmv_pkg::res_t                    head_o,
  output logic [csrspmv_pkg::FifoCntW-1:0]     count_o
);

  csrspmv_pkg::res_t                   entries_q [csrspmv_pkg::FifoDepth];
  logic [csrspmv_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [csrspmv_pkg::FifoCntW-1:0]    count_q;
  logic                                do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign head_o      = entries_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

/* src/csr_sparse_matrix_vector_multiply_top.sv */
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top
// CSR sparse matrix times vector: loads x, accumulates row dot products and
// emits one saturated Q-format sum per closed row.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  input    | in_valid_i/in_ready_o, func, index, value,| in
//           | row_end                                   |
//  result   | out_valid_o/out_ready_i, row_sum,         | out
//           | row_number, saturated, bad_column         |
//  config   | cfg_we_i, cfg_wdata_i (column_base)       | in
//
// One item per cycle while in_ready_o is high. The vector store read happens at
// the transfer edge; a closing row then passes the multiply, accumulate and
// result queue write steps in that order before it shows up at the output.
// Reset clears the row sum, bad flag, row counter and column base; the vector
// store is not cleared. in_ready_o drops while the result queue plus the items
// still in the pipeline take all 8 queue entries.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_top #(
  parameter int unsigned VECTOR_DEPTH  = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [csrspmv_pkg::IndexW-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             func_i,
  input  logic [csrspmv_pkg::IndexW-1:0]         index_i,
  input  logic signed [csrspmv_pkg::ValueW-1:0]  value_i,
  input  logic                                   row_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [csrspmv_pkg::ValueW-1:0]  row_sum_o,
  output logic [csrspmv_pkg::RowNumW-1:0]        row_number_o,
  output logic                                   saturated_o,
  output logic                                   bad_column_o
);

  localparam int unsigned AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [csrspmv_pkg::IndexW:0] DepthW = (csrspmv_pkg::IndexW + 1)'(VECTOR_DEPTH);

  logic [csrspmv_pkg::IndexW-1:0]         column_base_q;
  csrspmv_pkg::op_t                       op1_q, op1_d;
  logic signed [csrspmv_pkg::ValueW-1:0]  coef_q;
  logic                                   accept;
  logic                                   is_write, is_nonzero, is_empty;
  logic [csrspmv_pkg::IndexW:0]           col_diff;
  logic                                   col_ok, wr_ok;
  logic signed [csrspmv_pkg::ValueW-1:0]  x_rd;
  logic [1:0]                             mac_inflight;
  logic                                   mac_push;
  csrspmv_pkg::res_t                      mac_res;
  csrspmv_pkg::res_t                      head;
  logic [csrspmv_pkg::FifoCntW-1:0]       fifo_count;
  logic [csrspmv_pkg::FifoCntW-1:0]       pending;

  assign accept     = in_valid_i && in_ready_o;
  assign is_write   = (func_i == csrspmv_pkg::FuncVecWrite);
  assign is_nonzero = (func_i == csrspmv_pkg::FuncNonzero);
  assign is_empty   = (func_i == csrspmv_pkg::FuncEmptyRow);

  // A column below the base wraps to a huge difference and fails the compare too.
  assign col_diff = {1'b0, index_i} - {1'b0, column_base_q};
  assign col_ok   = (col_diff < DepthW);
  assign wr_ok    = ({1'b0, index_i} < DepthW);

  always_comb begin
    op1_d.valid     = accept && (is_nonzero || is_empty);
    op1_d.empty_row = is_empty;
    op1_d.row_end   = row_end_i;
    op1_d.bad       = is_nonzero && !col_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_base_q <= '0;
      op1_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        column_base_q <= cfg_wdata_i;
      end
      op1_q <= op1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= value_i;
  end

  csrspmv_vec_store #(
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && is_write && wr_ok),
    .wr_addr_i (index_i[AddrW-1:0]),
    .wr_data_i (value_i),
    .rd_en_i   (accept && is_nonzero && col_ok),
    .rd_addr_i (col_diff[AddrW-1:0]),
    .rd_data_o (x_rd)
  );

  csrspmv_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op1_q),
    .coef_i     (coef_q),
    .x_i        (x_rd),
    .inflight_o (mac_inflight),
    .push_o     (mac_push),
    .res_o      (mac_res)
  );

  csrspmv_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (mac_push),
    .push_data_i (mac_res),
    .pop_i       (out_ready_i),
    .not_empty_o (out_valid_o),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  // Reserve a queue slot for every item that may still produce a result.
  assign pending    = fifo_count + csrspmv_pkg::FifoCntW'(op1_q.valid)
                    + csrspmv_pkg::FifoCntW'(mac_inflight);
  assign in_ready_o = (pending < csrspmv_pkg::FifoCntW'(csrspmv_pkg::FifoDepth));

  assign row_sum_o    = head.row_sum;
  assign row_number_o = head.row_number;
  assign saturated_o  = head.saturated;
  assign bad_column_o = head.bad_column;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_push |-> (fifo_count < csrspmv_pkg::FifoCntW'(csrspmv_pkg::FifoDepth)))
    else $error("result queue overflow");

  a_empty_row_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_empty) |-> ##3 mac_push)
    else $error("empty row transfer gave no result");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write) |-> ##3 !mac_push)
    else $error("vector write produced a result");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (row_sum_o == 32'sh7FFF_FFFF) || (row_sum_o == 32'sh8000_0000))
    else $error("saturated result not at a limit");

endmodule

/* dv/csr_sparse_matrix_vector_multiply_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top_test
// Self-checking bench for the CSR sparse matrix-vector block. A queue of items
// feeds a paced driver. Each accepted transfer runs through a local row
// predictor, and the monitor compares every result transfer field by field.
// A short directed set comes first, with 32-bit clamping and floor rounding.
// Random phases under several column bases follow, each with its own mix of
// rows, vector writes and noise.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_top_test;

  localparam int unsigned IndexW        = csrspmv_pkg::IndexW;
  localparam int unsigned ValueW        = csrspmv_pkg::ValueW;
  localparam int unsigned RowNumW       = csrspmv_pkg::RowNumW;
  localparam int unsigned VectorDepth   = 1024;
  localparam int unsigned FracBits      = 16;
  localparam logic [1:0]  FuncUnused    = 2'd3;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReports    = 40;

  localparam logic [IndexW-1:0]        IndexMax = '1;
  localparam logic signed [ValueW-1:0] ValMax   = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] ValMin   = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] One      = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]               func;
    logic [IndexW-1:0]        index;
    logic signed [ValueW-1:0] value;
    logic                     row_end;
  } spmv_item_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [IndexW-1:0]          cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 func_i      = '0;
  logic [IndexW-1:0]          index_i     = '0;
  logic signed [ValueW-1:0]   value_i     = '0;
  logic                       row_end_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [ValueW-1:0]   row_sum_o;
  logic [RowNumW-1:0]         row_number_o;
  logic                       saturated_o;
  logic                       bad_column_o;

  // predictor state
  logic signed [ValueW-1:0] x_copy [VectorDepth];
  longint                   row_acc         = 0;
  logic [RowNumW-1:0]       rows_closed     = '0;
  bit                       row_bad         = 1'b0;
  int unsigned              column_base_now = 0;

  // stimulus bookkeeping
  bit                 written [VectorDepth];
  int unsigned        written_list [$];
  spmv_item_t         pending_items [$];
  csrspmv_pkg::res_t  expected_rows [$];
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  logic [15:0]        stall_pattern = '1;
  logic [4:0]         pattern_age = '0;
  int unsigned        error_count = 0;
  int unsigned        reports = 0;
  int unsigned        cycle_count = 0;

  csr_sparse_matrix_vector_multiply_top #(
    .VECTOR_DEPTH (VectorDepth),
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .row_end_i   (row_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_sum_o   (row_sum_o),
    .row_number_o(row_number_o),
    .saturated_o (saturated_o),
    .bad_column_o(bad_column_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the row state by one item; return 1 when the item closes a row.
  function automatic bit compute_row_result(input spmv_item_t item,
                                            output csrspmv_pkg::res_t row);
    int unsigned col;
    longint      prod;
    longint      sum;
    bit          closes;
    col    = 32'(item.index);
    closes = 1'b0;
    row    = '0;
    case (item.func)
      csrspmv_pkg::FuncVecWrite: begin
        if (col < VectorDepth) x_copy[col] = item.value;
      end
      csrspmv_pkg::FuncNonzero: begin
        if (col < column_base_now || col - column_base_now >= VectorDepth) begin
          row_bad = 1'b1;
        end else begin
          prod = (longint'(signed'(item.value)) *
                  longint'(signed'(x_copy[col - column_base_now]))) >>> FracBits;
          sum = row_acc + prod;
          // stick at the 64-bit limits instead of wrapping
          if (row_acc[63] == prod[63] && sum[63] != row_acc[63]) begin
            sum = row_acc[63] ? csrspmv_pkg::AccMin : csrspmv_pkg::AccMax;
          end
          row_acc = sum;
        end
        closes = item.row_end;
      end
      csrspmv_pkg::FuncEmptyRow: begin
        // drop any partial row
        row_acc = 0;
        row_bad = 1'b0;
        closes  = 1'b1;
      end
      default: ;
    endcase
    if (closes) begin
      row.row_number = rows_closed;
      row.bad_column = row_bad;
      if (row_acc > csrspmv_pkg::SumMax32) begin
        row.row_sum   = ValMax;
        row.saturated = 1'b1;
      end else if (row_acc < csrspmv_pkg::SumMin32) begin
        row.row_sum   = ValMin;
        row.saturated = 1'b1;
      end else begin
        row.row_sum = row_acc[31:0];
      end
      rows_closed = rows_closed + 1'b1;
      row_acc     = 0;
      row_bad     = 1'b0;
    end
    return closes;
  endfunction

  function automatic void queue_item(input logic [1:0] func, input int unsigned index,
                                     input logic signed [ValueW-1:0] value,
                                     input logic row_end);
    spmv_item_t item;
    item.func    = func;
    item.index   = IndexW'(index);
    item.value   = value;
    item.row_end = row_end;
    pending_items.insert(pending_items.size(), item);
    if (func == csrspmv_pkg::FuncVecWrite && index < VectorDepth && !written[index]) begin
      written[index] = 1'b1;
      written_list.insert(written_list.size(), index);
    end
  endfunction

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2:    return $urandom;
      3, 4, 5, 6: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      7:          return ValMax;
      8:          return ValMin;
      default:    return $urandom_range(0, 1) ? One : -One;
    endcase
  endfunction

  // Never point at a store entry that has not been written yet.
  function automatic int unsigned pick_column(input bit want_valid);
    int unsigned slot;
    int unsigned col;
    int unsigned reach;
    reach = 32'h0010_0000 - column_base_now;
    if (want_valid && written_list.size() != 0) begin
      repeat (8) begin
        if (reach < VectorDepth) slot = $urandom_range(0, reach - 1);
        else slot = written_list[$urandom_range(0, written_list.size() - 1)];
        if (written[slot]) return column_base_now + slot;
      end
    end
    // outside the window: hit its edges now and then
    if ($urandom_range(0, 3) == 0 && column_base_now > 0) return column_base_now - 1;
    if ($urandom_range(0, 3) == 0 && column_base_now + VectorDepth <= IndexMax) begin
      return column_base_now + VectorDepth;
    end
    do col = $urandom_range(0, IndexMax);
    while (col >= column_base_now && col - column_base_now < VectorDepth);
    return col;
  endfunction

  function automatic void queue_directed_items();
    queue_item(csrspmv_pkg::FuncVecWrite, 0, ValMax, 1'b1);
    queue_item(csrspmv_pkg::FuncVecWrite, 1, ValMin, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, 2, One, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, 3, -One, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, 4, 32'sd1, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, VectorDepth - 1, 32'sh0002_8000, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, VectorDepth, 32'sh1234_5678, 1'b0);
    queue_item(csrspmv_pkg::FuncVecWrite, IndexMax, 32'shA5A5_5A5A, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, 2, 3 * One, 1'b0);
    queue_item(csrspmv_pkg::FuncNonzero, VectorDepth - 1, -One, 1'b1);
    // floor rounding of a tiny negative product
    queue_item(csrspmv_pkg::FuncNonzero, 4, -32'sd1, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, VectorDepth, 32'sd5, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, IndexMax, 32'sd7, 1'b0);
    queue_item(csrspmv_pkg::FuncNonzero, 3, 2 * One, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, 2, 32'sd7, 1'b0);
    queue_item(csrspmv_pkg::FuncEmptyRow, IndexMax, ValMin, 1'b1);
    queue_item(FuncUnused, IndexMax, ValMax, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, 0, ValMax, 1'b0);
    queue_item(csrspmv_pkg::FuncNonzero, 0, ValMax, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, 1, ValMax, 1'b1);
    queue_item(csrspmv_pkg::FuncNonzero, 1, ValMin, 1'b1);
    queue_item(csrspmv_pkg::FuncEmptyRow, 0, 0, 1'b0);
  endfunction

  function automatic void queue_random_phase(input int unsigned count);
    int unsigned counted;
    int unsigned choice;
    int unsigned len;
    int unsigned idx;
    counted = 0;
    while (counted < count) begin
      choice = $urandom_range(0, 19);
      if (choice < 12) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++) begin
          queue_item(csrspmv_pkg::FuncNonzero, pick_column($urandom_range(0, 19) != 0),
                     rand_value(), k == len - 1);
        end
        counted += len;
      end else if (choice < 14) begin
        queue_item(csrspmv_pkg::FuncEmptyRow, $urandom, $urandom,
                   1'($urandom_range(0, 1)));
        counted++;
      end else if (choice < 17) begin
        if ($urandom_range(0, 7) == 0) idx = $urandom_range(VectorDepth, IndexMax);
        else idx = $urandom_range(0, VectorDepth - 1);
        queue_item(csrspmv_pkg::FuncVecWrite, idx, rand_value(), 1'($urandom_range(0, 1)));
        if (idx < VectorDepth) counted++;
      end else if (choice == 17) begin
        // row left open, then cut off by an empty row
        len = $urandom_range(1, 3);
        for (int unsigned k = 0; k < len; k++) begin
          queue_item(csrspmv_pkg::FuncNonzero, pick_column(1'b1), rand_value(), 1'b0);
        end
        queue_item(csrspmv_pkg::FuncEmptyRow, $urandom, $urandom,
                   1'($urandom_range(0, 1)));
        counted += len + 1;
      end else if (choice == 18) begin
        queue_item(FuncUnused, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        queue_item(csrspmv_pkg::FuncNonzero, pick_column(1'b0), rand_value(),
                   1'($urandom_range(0, 1)));
        counted++;
      end
    end
  endfunction

  function automatic logic [15:0] next_stall_pattern();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return 16'($urandom);
      2:       return 16'($urandom | $urandom);
      default: return 16'($urandom & $urandom) | 16'h0001;
    endcase
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    error_count++;
    if (reports < MaxReports) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      reports++;
    end
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_valid_i || expected_rows.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_column_base(input int unsigned base);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= IndexW'(base);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    column_base_now = base;
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    spmv_item_t        next_item;
    spmv_item_t        sent;
    csrspmv_pkg::res_t row;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent.func    = func_i;
        sent.index   = index_i;
        sent.value   = value_i;
        sent.row_end = row_end_i;
        if (compute_row_result(sent, row)) expected_rows.insert(expected_rows.size(), row);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item  = pending_items.pop_front();
          func_i     <= next_item.func;
          index_i    <= next_item.index;
          value_i    <= next_item.value;
          row_end_i  <= next_item.row_end;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall on a rotating pattern, check every result transfer.
  always @(posedge clk_i or negedge rst_ni) begin : check_rows
    csrspmv_pkg::res_t want;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      stall_pattern <= '1;
      pattern_age   <= '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          error_count++;
          if (reports < MaxReports) begin
            $display("%0t: result with none expected, expected nothing, actual row %0d",
                     $time, row_number_o);
            reports++;
          end
        end else begin
          want = expected_rows.pop_front();
          if (row_sum_o !== want.row_sum) begin
            note_mismatch("row_sum", longint'(want.row_sum), longint'(row_sum_o));
          end
          if (row_number_o !== want.row_number) begin
            note_mismatch("row_number", longint'(want.row_number), longint'(row_number_o));
          end
          if (saturated_o !== want.saturated) begin
            note_mismatch("saturated", longint'(want.saturated), longint'(saturated_o));
          end
          if (bad_column_o !== want.bad_column) begin
            note_mismatch("bad_column", longint'(want.bad_column), longint'(bad_column_o));
          end
        end
      end
      out_ready_i <= stall_pattern[0];
      pattern_age <= pattern_age + 1'b1;
      if (pattern_age == 5'd31) stall_pattern <= next_stall_pattern();
      else stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timed out with %0d rows outstanding", $time, expected_rows.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_phases
    int unsigned bases [7];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    queue_directed_items();
    drain_and_settle();
    bases = '{32'(IndexMax), 32'h000F_FC00, 777, $urandom_range(1, IndexMax), 0,
              $urandom_range(0, 4095), 3};
    foreach (bases[k]) begin
      write_column_base(bases[k]);
      @(negedge clk_i);
      queue_random_phase(ItemsPerPhase);
      drain_and_settle();
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/csrspmv_pkg.sv
src/csrspmv_vec_store.sv
src/csrspmv_mac.sv
src/csrspmv_out_fifo.sv
src/csr_sparse_matrix_vector_multiply_top.sv
dv/csr_sparse_matrix_vector_multiply_top_test.sv
